>>> rtl/tcsw_pkg.sv
// Shared types, constants and tag lookup for the tagged chunk stream walker.
package tcsw_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int NUM_TAGS = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  localparam logic [3:0] KIND_UNKNOWN = 4'd9;

  localparam logic [1:0] RK_HEADER = 2'd0;
  localparam logic [1:0] RK_PAYLOAD = 2'd1;
  localparam logic [1:0] RK_DONE_OK = 2'd2;
  localparam logic [1:0] RK_DONE_TRUNC = 2'd3;

  localparam logic [0:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [0:0] REG_ENABLED_KINDS = 1'd1;

  // Tag bytes in the order they appear in the stream.
  localparam logic [7:0] TAGS [NUM_TAGS][4] = '{
    '{8'h52, 8'h45, 8'h56, 8'h4D},
    '{8'h44, 8'h48, 8'h50, 8'h4D},
    '{8'h4E, 8'h49, 8'h41, 8'h4D},
    '{8'h4F, 8'h4D, 8'h57, 8'h4D},
    '{8'h46, 8'h44, 8'h4F, 8'h4D},
    '{8'h58, 8'h45, 8'h54, 8'h4D},
    '{8'h4B, 8'h4E, 8'h43, 8'h4D},
    '{8'h54, 8'h56, 8'h43, 8'h4D},
    '{8'h59, 8'h4C, 8'h43, 8'h4D}
  };

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  chunk_kind;
    logic [31:0] chunk_size;
    logic [7:0]  payload_byte;
    logic        last_in_chunk;
    logic        last;
  } result_t;

  // Tag is given with the first stream byte in the top bits.
  function automatic logic [3:0] classify_tag(input logic [31:0] tag);
    logic [3:0] kind;
    kind = KIND_UNKNOWN;
    for (int k = NUM_TAGS - 1; k >= 0; k--) begin
      if (tag[31:24] == TAGS[k][0] && tag[23:16] == TAGS[k][1] &&
          tag[15:8] == TAGS[k][2] && tag[7:0] == TAGS[k][3]) begin
        kind = 4'(k);
      end
    end
    return kind;
  endfunction

endpackage

>>> rtl/tagged_chunk_stream_walker.sv
// Tagged chunk stream walker: splits a byte stream into chunks and emits results.
// One input beat per clock while s_tready is high; a beat is parsed in the cycle it is taken.
// The results of an input beat are registered in the queue and leave from its head.
// Results pass through a four-entry queue; input is taken while at least two entries are free.
// Synchronous active-high reset clears the walk, the queue and the registers
// (buffer_length to zero, enabled_kinds to all ones); writing buffer_length restarts the walk.
module tagged_chunk_stream_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // chunk_size, payload_byte, last_in_chunk, zero fill
  output logic [5:0]  m_tuser,   // result_kind, chunk_kind
  output logic        m_tlast    // last
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FAILED  = 2'd2
  } phase_t;

  logic [31:0] buffer_length;
  logic [8:0]  enabled_kinds;
  logic [31:0] byte_position;
  logic [55:0] header_bytes;
  logic [2:0]  header_fill;
  phase_t      walk_phase;
  logic [31:0] payload_remaining;
  logic [31:0] current_size;
  logic [3:0]  current_kind;
  logic        deliver_current;

  logic [55:0] header_bytes_next;
  logic [2:0]  header_fill_next;
  phase_t      walk_phase_next;
  logic [31:0] payload_remaining_next;
  logic [31:0] current_size_next;
  logic [3:0]  current_kind_next;
  logic        deliver_current_next;

  tcsw_pkg::result_t fifo_mem [tcsw_pkg::FIFO_DEPTH];
  logic [tcsw_pkg::PTR_W-1:0] wr_ptr;
  logic [tcsw_pkg::PTR_W-1:0] rd_ptr;
  logic [tcsw_pkg::CNT_W-1:0] count;

  logic        in_fire;
  logic        out_fire;
  logic        active;
  logic [31:0] pos_next;
  logic        final_byte;
  logic [63:0] hb_full;
  logic [31:0] hdr_size;
  logic [32:0] end_sum;
  logic [3:0]  hdr_kind;
  logic        hdr_deliver;
  logic        have_primary;
  logic        have_status;
  tcsw_pkg::result_t primary;
  tcsw_pkg::result_t status;
  tcsw_pkg::result_t push0;
  tcsw_pkg::result_t push1;
  logic [1:0]  push_n;
  tcsw_pkg::result_t head;

  assign s_tready = (count <= tcsw_pkg::CNT_W'(tcsw_pkg::FIFO_DEPTH - 2));
  assign in_fire = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign out_fire = m_tvalid && m_tready;

  assign active = (byte_position < buffer_length);
  assign pos_next = byte_position + 32'd1;
  assign final_byte = (pos_next == buffer_length);
  assign hb_full = {header_bytes, s_tdata};
  assign hdr_size = {hb_full[7:0], hb_full[15:8], hb_full[23:16], hb_full[31:24]};
  assign end_sum = {1'b0, pos_next} + {1'b0, hdr_size};
  assign hdr_kind = tcsw_pkg::classify_tag(hb_full[63:32]);
  assign hdr_deliver = (hdr_kind != tcsw_pkg::KIND_UNKNOWN) && enabled_kinds[hdr_kind];

  always_comb begin
    header_bytes_next = header_bytes;
    header_fill_next = header_fill;
    walk_phase_next = walk_phase;
    payload_remaining_next = payload_remaining;
    current_size_next = current_size;
    current_kind_next = current_kind;
    deliver_current_next = deliver_current;
    have_primary = 1'b0;
    primary = '0;
    case (walk_phase)
      PH_HEADER: begin
        header_bytes_next = hb_full[55:0];
        header_fill_next = header_fill + 3'd1;
        if (header_fill == 3'(tcsw_pkg::HEADER_BYTES - 1)) begin
          if (end_sum > {1'b0, buffer_length}) begin
            walk_phase_next = PH_FAILED;
          end else begin
            current_kind_next = hdr_kind;
            current_size_next = hdr_size;
            deliver_current_next = hdr_deliver;
            payload_remaining_next = hdr_size;
            walk_phase_next = (hdr_size == '0) ? PH_HEADER : PH_PAYLOAD;
            have_primary = hdr_deliver;
            primary.result_kind = tcsw_pkg::RK_HEADER;
            primary.chunk_kind = hdr_kind;
            primary.chunk_size = hdr_size;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_remaining_next = payload_remaining - 32'd1;
        have_primary = deliver_current;
        primary.result_kind = tcsw_pkg::RK_PAYLOAD;
        primary.chunk_kind = current_kind;
        primary.chunk_size = current_size;
        primary.payload_byte = s_tdata;
        primary.last_in_chunk = (payload_remaining == 32'd1);
        if (payload_remaining == 32'd1) begin
          walk_phase_next = PH_HEADER;
        end
      end
      default: begin
        walk_phase_next = walk_phase;
      end
    endcase
    primary.last = !final_byte;
    primary.last = !final_byte ? 1'b1 : 1'b0;
  end

  always_comb begin
    have_status = final_byte;
    status = '0;
    status.result_kind = (walk_phase_next == PH_FAILED) ? tcsw_pkg::RK_DONE_TRUNC
                                                        : tcsw_pkg::RK_DONE_OK;
    status.last = 1'b1;
    if (have_primary) begin
      push0 = primary;
      push1 = status;
      push_n = have_status ? 2'd2 : 2'd1;
    end else begin
      push0 = status;
      push1 = status;
      push_n = have_status ? 2'd1 : 2'd0;
    end
    if (!(in_fire && active)) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= '0;
      enabled_kinds <= '1;
      byte_position <= '0;
      header_bytes <= '0;
      header_fill <= '0;
      walk_phase <= PH_HEADER;
      payload_remaining <= '0;
      current_size <= '0;
      current_kind <= tcsw_pkg::KIND_UNKNOWN;
      deliver_current <= 1'b0;
    end else if (cfg_we && cfg_index == tcsw_pkg::REG_BUFFER_LENGTH) begin
      buffer_length <= cfg_data;
      byte_position <= '0;
      header_bytes <= '0;
      header_fill <= '0;
      walk_phase <= PH_HEADER;
      payload_remaining <= '0;
      current_size <= '0;
      current_kind <= tcsw_pkg::KIND_UNKNOWN;
      deliver_current <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == tcsw_pkg::REG_ENABLED_KINDS) begin
        enabled_kinds <= cfg_data[8:0];
      end
      if (in_fire && active) begin
        byte_position <= pos_next;
        header_bytes <= header_bytes_next;
        header_fill <= header_fill_next;
        walk_phase <= walk_phase_next;
        payload_remaining <= payload_remaining_next;
        current_size <= current_size_next;
        current_kind <= current_kind_next;
        deliver_current <= deliver_current_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + tcsw_pkg::PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + tcsw_pkg::PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + tcsw_pkg::PTR_W'(1);
      end
      count <= count + tcsw_pkg::CNT_W'(push_n) - tcsw_pkg::CNT_W'(out_fire);
    end
  end

  assign head = fifo_mem[rd_ptr];
  assign m_tdata = {7'b0, head.last_in_chunk, head.payload_byte, head.chunk_size};
  assign m_tuser = {head.chunk_kind, head.result_kind};
  assign m_tlast = head.last;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tcsw_pkg::CNT_W'(tcsw_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_two_only_on_final: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> final_byte)
    else $error("two results pushed for a byte that is not the final one");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (walk_phase == PH_PAYLOAD) |-> (payload_remaining != '0))
    else $error("payload phase with nothing left to take");

  a_past_end_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !active) |-> (push_n == 2'd0))
    else $error("result produced for a byte past the buffer");
`endif

endmodule

>>> test/tb_tagged_chunk_stream_walker.sv
// Self-checking testbench for the tagged chunk stream walker: directed table plus random buffers.
module tb_tagged_chunk_stream_walker;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES = 400;
  localparam int HOLD_AFTER = 60;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {
    WALK_HEADER  = 2'd0,
    WALK_PAYLOAD = 2'd1,
    WALK_FAILED  = 2'd2
  } walk_phase_e;

  typedef struct {
    bit          is_cfg;
    logic [0:0]  reg_idx;
    logic [31:0] value;
    bit          typed;
    bit          has_want;
    tcsw_pkg::result_t want;
  } step_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // chunk_size, payload_byte, last_in_chunk, zero fill
  logic [5:0]  m_tuser;   // result_kind, chunk_kind
  logic        m_tlast;

  tagged_chunk_stream_walker uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  logic [31:0] buf_len;
  logic [8:0]  kinds_en;
  logic [31:0] walk_pos;
  logic [63:0] hdr_shift;
  int unsigned hdr_fill;
  walk_phase_e walk_phase;
  logic [31:0] payload_left;
  logic [31:0] cur_size;
  logic [3:0]  cur_kind;
  bit          deliver;

  tcsw_pkg::result_t byte_results[$];
  tcsw_pkg::result_t pending_results[$];
  step_t   plan[$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit steady = 0;
  int random_sent = 0;

  int taken = 0;
  int hold_left = 0;
  bit held = 0;
  int rx_cycle = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic tcsw_pkg::result_t mk_result(logic [1:0] rk, logic [3:0] ck,
                                                  logic [31:0] sz, logic [7:0] pb, logic lic);
    tcsw_pkg::result_t r;
    r.result_kind = rk;
    r.chunk_kind = ck;
    r.chunk_size = sz;
    r.payload_byte = pb;
    r.last_in_chunk = lic;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic tcsw_pkg::result_t done_beat(logic [1:0] rk);
    tcsw_pkg::result_t r;
    r = mk_result(rk, 4'd0, 32'd0, 8'd0, 1'b0);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void restart_walk();
    walk_pos = '0;
    hdr_shift = '0;
    hdr_fill = 0;
    walk_phase = WALK_HEADER;
    payload_left = '0;
    cur_size = '0;
    cur_kind = tcsw_pkg::KIND_UNKNOWN;
    deliver = 1'b0;
  endfunction

  // Advances the walk by one byte and collects the results it causes in byte_results.
  function automatic void walk_byte(logic [7:0] b);
    logic [31:0] sz;
    bit final_byte;
    bit failed;
    int k;
    byte_results = {};
    if (walk_pos >= buf_len) return;
    walk_pos = walk_pos + 32'd1;
    final_byte = (walk_pos == buf_len);
    case (walk_phase)
      WALK_HEADER: begin
        hdr_shift = {hdr_shift[55:0], b};
        hdr_fill++;
        if (hdr_fill == tcsw_pkg::HEADER_BYTES) begin
          hdr_fill = 0;
          sz = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16], hdr_shift[31:24]};
          if ({1'b0, walk_pos} + {1'b0, sz} > {1'b0, buf_len}) begin
            walk_phase = WALK_FAILED;
          end else begin
            cur_kind = tcsw_pkg::KIND_UNKNOWN;
            for (k = 0; k < tcsw_pkg::NUM_TAGS; k++) begin
              if (cur_kind == tcsw_pkg::KIND_UNKNOWN &&
                  hdr_shift[63:32] == {tcsw_pkg::TAGS[k][0], tcsw_pkg::TAGS[k][1],
                                       tcsw_pkg::TAGS[k][2], tcsw_pkg::TAGS[k][3]}) begin
                cur_kind = 4'(k);
              end
            end
            cur_size = sz;
            deliver = (cur_kind != tcsw_pkg::KIND_UNKNOWN) && kinds_en[cur_kind];
            payload_left = sz;
            walk_phase = (sz == 0) ? WALK_HEADER : WALK_PAYLOAD;
            if (deliver) begin
              byte_results.push_back(mk_result(tcsw_pkg::RK_HEADER, cur_kind, sz, 8'd0, 1'b0));
            end
          end
        end
      end
      WALK_PAYLOAD: begin
        if (payload_left != 0) payload_left = payload_left - 32'd1;
        if (deliver) begin
          byte_results.push_back(mk_result(tcsw_pkg::RK_PAYLOAD, cur_kind, cur_size, b,
                                           payload_left == 0));
        end
        if (payload_left == 0) walk_phase = WALK_HEADER;
      end
      default: ;
    endcase
    if (final_byte) begin
      failed = (walk_phase != WALK_HEADER) && (walk_phase != WALK_PAYLOAD);
      byte_results.push_back(mk_result(failed ? tcsw_pkg::RK_DONE_TRUNC : tcsw_pkg::RK_DONE_OK,
                                       4'd0, 32'd0, 8'd0, 1'b0));
    end
    if (byte_results.size() != 0) byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  function automatic step_t cfg_row(logic [0:0] idx, logic [31:0] val);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.value = val;
    s.typed = 1'b0;
    s.has_want = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t byte_row(logic [7:0] b);
    step_t s;
    s = cfg_row(tcsw_pkg::REG_BUFFER_LENGTH, {24'd0, b});
    s.is_cfg = 1'b0;
    return s;
  endfunction

  function automatic step_t typed_row(logic [7:0] b, bit has_want, tcsw_pkg::result_t want);
    step_t s;
    s = byte_row(b);
    s.typed = 1'b1;
    s.has_want = has_want;
    s.want = want;
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic cfg_write(logic [0:0] idx, logic [31:0] val);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcsw_pkg::REG_BUFFER_LENGTH) begin
      buf_len = val;
      restart_walk();
    end else begin
      kinds_en = val[8:0];
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if (!steady) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_byte(logic [7:0] b, bit typed, bit has_want, tcsw_pkg::result_t want);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    walk_byte(b);
    if (typed) begin
      if (has_want) pending_results.push_back(want);
    end else begin
      foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
    end
  endtask

  task automatic random_buffer();
    logic [7:0]  image[$];
    logic [31:0] sz;
    logic [31:0] tag;
    logic [31:0] len;
    logic [8:0]  kinds;
    int shape;
    int chunks;
    int k;
    image = {};
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      repeat ($urandom_range(1, 30)) image.push_back(8'($urandom));
    end else if (shape == 4) begin
      k = $urandom_range(0, tcsw_pkg::NUM_TAGS - 1);
      tag = {tcsw_pkg::TAGS[k][0], tcsw_pkg::TAGS[k][1], tcsw_pkg::TAGS[k][2],
             tcsw_pkg::TAGS[k][3]};
      sz = 32'h8000_0000 | ($urandom & 32'h7FFF_FFF0);
      for (int i = 3; i >= 0; i--) image.push_back(tag[8*i +: 8]);
      for (int i = 0; i < 4; i++) image.push_back(sz[8*i +: 8]);
      repeat ($urandom_range(4, 16)) image.push_back(8'($urandom));
    end else begin
      chunks = $urandom_range(1, 4);
      for (int c = 0; c < chunks; c++) begin
        k = $urandom_range(0, tcsw_pkg::NUM_TAGS);
        if (k == tcsw_pkg::NUM_TAGS) tag = $urandom;
        else tag = {tcsw_pkg::TAGS[k][0], tcsw_pkg::TAGS[k][1], tcsw_pkg::TAGS[k][2],
                    tcsw_pkg::TAGS[k][3]};
        sz = $urandom_range(0, 6);
        if (shape == 1 && c == chunks - 1) sz = $urandom | 32'h100;
        for (int i = 3; i >= 0; i--) image.push_back(tag[8*i +: 8]);
        for (int i = 0; i < 4; i++) image.push_back(sz[8*i +: 8]);
        if (sz > 6) sz = $urandom_range(0, 5);
        repeat (sz) image.push_back(8'($urandom));
      end
      if (shape == 2) repeat ($urandom_range(1, 7)) image.push_back(8'($urandom));
    end
    len = 32'(image.size());
    if (shape == 3) len = 32'($urandom_range(0, image.size()));
    if (shape == 4) len = 32'hFFFF_FFFF;
    case ($urandom_range(0, 5))
      0: kinds = 9'd0;
      1: kinds = 9'h1FF;
      default: kinds = 9'($urandom_range(0, 511));
    endcase
    cfg_write(tcsw_pkg::REG_ENABLED_KINDS, {23'd0, kinds});
    cfg_write(tcsw_pkg::REG_BUFFER_LENGTH, len);
    steady = ($urandom_range(0, 3) == 0);
    foreach (image[i]) begin
      pace();
      send_byte(image[i], 1'b0, 1'b0, '0);
    end
    random_sent += image.size();
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_tagged_chunk_stream_walker: FAIL");
      $finish;
    end
  end

  // The receiver has its own stall pattern and one long hold-off that backs up the block.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) taken++;
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held && taken >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 50) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= rx_cycle[0];
      endcase
    end
    rx_cycle++;
  end

  always @(posedge clk) begin : result_check
    tcsw_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tuser %0h tdata %0h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(m_tuser[1:0]));
        check_field("chunk_kind", 32'(want.chunk_kind), 32'(m_tuser[5:2]));
        check_field("chunk_size", want.chunk_size, m_tdata[31:0]);
        check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[39:32]));
        check_field("last_in_chunk", 32'(want.last_in_chunk), 32'(m_tdata[40]));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  initial begin
    buf_len = '0;
    kinds_en = 9'h1FF;
    restart_walk();

    // Empty buffer after reset, a one-byte short tail, a delivered chunk with a byte
    // past the end, and an oversized chunk with every kind disabled.
    plan.push_back(typed_row(8'hFF, 1'b0, '0));
    plan.push_back(cfg_row(tcsw_pkg::REG_ENABLED_KINDS, 32'h1FF));
    plan.push_back(cfg_row(tcsw_pkg::REG_BUFFER_LENGTH, 32'd1));
    plan.push_back(typed_row(8'h00, 1'b1, done_beat(tcsw_pkg::RK_DONE_OK)));
    plan.push_back(cfg_row(tcsw_pkg::REG_BUFFER_LENGTH, 32'd10));
    plan.push_back(byte_row(8'h52));
    plan.push_back(byte_row(8'h45));
    plan.push_back(byte_row(8'h56));
    plan.push_back(byte_row(8'h4D));
    plan.push_back(byte_row(8'h02));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'h00));
    plan.push_back(typed_row(8'h80, 1'b0, '0));
    plan.push_back(cfg_row(tcsw_pkg::REG_ENABLED_KINDS, 32'h000));
    plan.push_back(cfg_row(tcsw_pkg::REG_BUFFER_LENGTH, 32'd8));
    plan.push_back(byte_row(8'h4B));
    plan.push_back(byte_row(8'h4E));
    plan.push_back(byte_row(8'h43));
    plan.push_back(byte_row(8'h4D));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(typed_row(8'h80, 1'b1, done_beat(tcsw_pkg::RK_DONE_TRUNC)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        cfg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        pace();
        send_byte(plan[i].value[7:0], plan[i].typed, plan[i].has_want, plan[i].want);
      end
    end

    while (random_sent < RANDOM_BYTES) random_buffer();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_tagged_chunk_stream_walker: PASS");
    end else begin
      $display("tb_tagged_chunk_stream_walker: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tcsw_pkg.sv
rtl/tagged_chunk_stream_walker.sv
test/tb_tagged_chunk_stream_walker.sv
